>>> hdl/lzss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

    localparam int EXP_W     = 24;
    localparam int DIST_W    = 12;
    localparam int LEN_W     = 5;
    localparam int FLAG_BITS = 8;
    localparam int LEN_BIAS  = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_status;
        logic       ok;
        logic       run_end;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/lzss_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink (input valid, input in_byte, input last_in, output ready);
endinterface

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic       ok;
    logic       run_end;

    modport source (output valid, output out_byte, output is_status, output ok,
                    output run_end, input ready);
    modport sink (input valid, input out_byte, input is_status, input ok,
                  input run_end, output ready);
endinterface

interface lzss_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] expected_length;

    modport source (output valid, output expected_length, input ready);
    modport sink (input valid, input expected_length, output ready);
endinterface

`default_nettype wire

>>> hdl/lzss_hist.sv
`timescale 1ns / 1ps
`default_nettype none

module lzss_hist #(
    parameter int DEPTH = 4096
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [7:0]                 wdata,
    input  wire                       re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [7:0]                rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lzss_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lzss_out_stage (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  lzss_pkg::out_item_t  item,
    output logic                 slot_free,
    lzss_out_if.source           decompressed
);

    import lzss_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign slot_free = !valid_reg || decompressed.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (decompressed.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg <= item;
        end
    end

    assign decompressed.valid     = valid_reg;
    assign decompressed.out_byte  = item_reg.data;
    assign decompressed.is_status = item_reg.is_status;
    assign decompressed.ok        = item_reg.ok;
    assign decompressed.run_end   = item_reg.run_end;

`ifndef SYNTHESIS
    a_push_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> slot_free)
        else $error("result pushed into a full output stage");
`endif

endmodule

`default_nettype wire

>>> hdl/lzss_stream_decompressor.sv
`timescale 1ns / 1ps
`default_nettype none

// LZSS decoder, 12-bit distance / 4-bit length, 4 KiB history in one RAM.
// One sequencer drives a single shared add-and-compare unit and the history
// RAM. A flag byte or first reference byte passes idle, parse and finish; a
// literal adds emit; the second reference byte adds a distance check, then a
// read and an emit per copied byte (len = 3..18), since every copied byte is
// a registered RAM read followed by a write of the same RAM; a last byte puts
// its status out in finish. Output stalls hold emit and that finish. Results
// sit in an output register, so the next request is taken while one still
// waits. No clearing pass: history reads never reach unwritten entries.
module lzss_stream_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int COUNT_BITS   = 24
) (
    input  wire          clk,
    input  wire          rst_n,
    lzss_cfg_if.sink     cfg,
    lzss_in_if.sink      compressed,
    lzss_out_if.source   decompressed
);

    import lzss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = ((COUNT_BITS > EXP_W) ? COUNT_BITS : EXP_W) + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PARSE   = 3'd1;
    localparam logic [2:0] S_CHKDIST = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]            state_reg,   state_next;
    logic [7:0]            byte_reg,    byte_next;
    logic                  last_reg,    last_next;
    logic [COUNT_BITS-1:0] pc_reg,      pc_next;
    logic [7:0]            flags_reg,   flags_next;
    logic [3:0]            fcnt_reg,    fcnt_next;
    logic                  phase_reg,   phase_next;
    logic [7:0]            low_reg,     low_next;
    logic                  failed_reg,  failed_next;
    logic [EXP_W-1:0]      exp_reg,     exp_next;
    logic [LEN_W-1:0]      cnt_reg,     cnt_next;
    logic [DIST_W-1:0]     dist_reg,    dist_next;
    logic                  copying_reg, copying_next;

    logic [CW-1:0]    cmp_a;
    logic [CW-1:0]    cmp_b;
    logic             cmp_gt;
    logic [LEN_W-1:0] len_w;

    logic             hist_we;
    logic             hist_re;
    logic [AW-1:0]    hist_raddr;
    logic [7:0]       hist_rdata;
    logic             push;
    logic             slot_free;
    out_item_t        item;

    assign len_w      = {1'b0, byte_reg[3:0]} + LEN_W'(LEN_BIAS);
    assign hist_raddr = pc_reg[AW-1:0] - AW'(dist_reg);
    assign hist_re    = (state_reg == S_READ);

    // shared add-and-compare unit
    always_comb
    begin
        cmp_a = CW'(pc_reg) + (phase_reg ? CW'(len_w) : CW'(1));
        cmp_b = CW'(exp_reg);
        if (state_reg == S_CHKDIST)
        begin
            cmp_a = CW'(dist_reg);
            cmp_b = CW'(pc_reg);
        end
    end
    assign cmp_gt = cmp_a > cmp_b;

    assign compressed.ready = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        pc_next      = pc_reg;
        flags_next   = flags_reg;
        fcnt_next    = fcnt_reg;
        phase_next   = phase_reg;
        low_next     = low_reg;
        failed_next  = failed_reg;
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        dist_next    = dist_reg;
        copying_next = copying_reg;
        hist_we      = 1'b0;
        push         = 1'b0;
        item         = '0;

        if (cfg.valid)
        begin
            exp_next = cfg.expected_length;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (compressed.valid)
                begin
                    byte_next  = compressed.in_byte;
                    last_next  = compressed.last_in;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                state_next = S_FINISH;
                if (!failed_reg)
                begin
                    phase_next = 1'b0;
                    if (phase_reg)
                    begin
                        dist_next = {byte_reg[7:4], low_reg};
                        cnt_next  = len_w;
                        if (cmp_gt)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_CHKDIST;
                        end
                    end
                    else if (cmp_gt)
                    begin
                        failed_next = 1'b1;
                    end
                    else if (fcnt_reg >= 4'(FLAG_BITS))
                    begin
                        flags_next = byte_reg;
                        fcnt_next  = '0;
                    end
                    else if (flags_reg[0])
                    begin
                        copying_next = 1'b0;
                        cnt_next     = LEN_W'(1);
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        low_next   = byte_reg;
                        phase_next = 1'b1;
                    end
                end
            end
            S_CHKDIST:
            begin
                if ((dist_reg == '0) || cmp_gt)
                begin
                    failed_next = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    copying_next = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                item.data    = copying_reg ? hist_rdata : byte_reg;
                item.run_end = (cnt_reg == LEN_W'(1)) && !last_reg;
                if (slot_free)
                begin
                    push    = 1'b1;
                    hist_we = 1'b1;
                    pc_next = pc_reg + COUNT_BITS'(1);
                    if (cnt_reg > LEN_W'(1))
                    begin
                        cnt_next   = cnt_reg - LEN_W'(1);
                        state_next = S_READ;
                    end
                    else
                    begin
                        flags_next = flags_reg >> 1;
                        fcnt_next  = fcnt_reg + 4'd1;
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                item.is_status = 1'b1;
                item.run_end   = 1'b1;
                item.ok        = !failed_reg && !phase_reg &&
                                 (CW'(pc_reg) == CW'(exp_reg));
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    push        = 1'b1;
                    pc_next     = '0;
                    flags_next  = '0;
                    fcnt_next   = 4'(FLAG_BITS);
                    phase_next  = 1'b0;
                    low_next    = '0;
                    failed_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            flags_reg   <= '0;
            fcnt_reg    <= 4'(FLAG_BITS);
            phase_reg   <= 1'b0;
            low_reg     <= '0;
            failed_reg  <= 1'b0;
            exp_reg     <= '0;
            cnt_reg     <= '0;
            copying_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            flags_reg   <= flags_next;
            fcnt_reg    <= fcnt_next;
            phase_reg   <= phase_next;
            low_reg     <= low_next;
            failed_reg  <= failed_next;
            exp_reg     <= exp_next;
            cnt_reg     <= cnt_next;
            copying_reg <= copying_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        dist_reg <= dist_next;
    end

    lzss_hist #(
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pc_reg[AW-1:0]),
        .wdata (item.data),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    lzss_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .item         (item),
        .slot_free    (slot_free),
        .decompressed (decompressed)
    );

`ifndef SYNTHESIS
    a_accept_to_parse: assert property (@(posedge clk) disable iff (!rst_n)
        compressed.valid && compressed.ready |=> state_reg == S_PARSE)
        else $error("accepted request not parsed next cycle");

    a_read_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> cnt_reg != '0 && copying_reg)
        else $error("history read without a pending copy");

    a_phase_needs_flag: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> fcnt_reg < 4'(FLAG_BITS))
        else $error("reference pending with no flag bit in hand");
`endif

endmodule

`default_nettype wire
